// File: rtl/core/bed_pkg.sv
// shared types, constants and helpers of the bite event detector
package bed_pkg;

	localparam int INT_WIDTH      = 24;
	localparam int WIDE_WIDTH     = INT_WIDTH + 3;
	localparam int COEF_REG_WIDTH = 16;
	localparam int THR_WIDTH      = 15;
	localparam int CNT_WIDTH      = 4;
	localparam int IDX_WIDTH      = 3;
	localparam int CFG_DATA_WIDTH = 16;

	typedef enum logic [IDX_WIDTH-1:0] {
		IDX_LP_WEIGHT       = 3'd0,
		IDX_HPF_DECAY       = 3'd1,
		IDX_FAST_THRESHOLD  = 3'd2,
		IDX_SLOW_THRESHOLD  = 3'd3,
		IDX_SLOW_RUN_LENGTH = 3'd4,
		IDX_LOCKOUT_LENGTH  = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [COEF_REG_WIDTH-1:0] lp_weight;
		logic [COEF_REG_WIDTH-1:0] hpf_decay;
		logic [THR_WIDTH-1:0]      fast_threshold;
		logic [THR_WIDTH-1:0]      slow_threshold;
		logic [CNT_WIDTH-1:0]      slow_run_length;
		logic [CNT_WIDTH-1:0]      lockout_length;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		lp_weight:       16'd19661,
		hpf_decay:       16'd58982,
		fast_threshold:  15'd369,
		slow_threshold:  15'd82,
		slow_run_length: 4'd3,
		lockout_length:  4'd10
	};

	typedef struct packed {
		logic load_s1;
		logic step_s2;
		logic step_s3;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [INT_WIDTH-1:0] lp;
		logic signed [INT_WIDTH-1:0] hp;
		logic [INT_WIDTH-1:0]        mag;
	} filt_t;

	typedef struct packed {
		logic bite;
		logic fast_hit;
		logic slow_hit;
		logic locked_out;
	} flags_t;

	// clamp a widened value to the internal signed range
	function automatic logic signed [INT_WIDTH-1:0] sat_int(
		input logic signed [WIDE_WIDTH-1:0] v
	);
		logic signed [INT_WIDTH-1:0] r;
		if (v[WIDE_WIDTH-1:INT_WIDTH-1] == {(WIDE_WIDTH-INT_WIDTH+1){v[WIDE_WIDTH-1]}}) begin
			r = v[INT_WIDTH-1:0];
		end else if (v[WIDE_WIDTH-1]) begin
			r = {1'b1, {(INT_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(INT_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: rtl/core/bed_sample_if.sv
// sample request channel
interface bed_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] z_sample;

	modport source (output valid, output z_sample, input ready);
	modport sink (input valid, input z_sample, output ready);
endinterface

// File: rtl/core/bed_result_if.sv
// result request channel
interface bed_result_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic                           bite;
	logic                           fast_hit;
	logic                           slow_hit;
	logic                           locked_out;
	logic signed [SAMPLE_WIDTH-1:0] high_pass_out;

	modport source (
		output valid, output bite, output fast_hit, output slow_hit,
		output locked_out, output high_pass_out, input ready
	);
	modport sink (
		input valid, input bite, input fast_hit, input slow_hit,
		input locked_out, input high_pass_out, output ready
	);
endinterface

// File: rtl/core/bed_filter.sv
// input register, low-pass and high-pass filter stage
module bed_filter #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bed_pkg::pipe_ctl_t             ctl,
	input  bed_pkg::cfg_t                  cfg,
	input  logic signed [SAMPLE_WIDTH-1:0] z_sample,
	output bed_pkg::filt_t                 filt_s2
);
	import bed_pkg::*;

	localparam int AXW = SAMPLE_WIDTH + COEF_WIDTH + 1;
	localparam int PW  = INT_WIDTH + COEF_WIDTH + 3;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (COEF_WIDTH - 1);

	logic [COEF_WIDTH+COEF_REG_WIDTH-1:0] alpha_ext, decay_ext;
	logic [COEF_WIDTH-1:0]                alpha, decay;
	logic [COEF_WIDTH:0]                  beta;

	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic signed [AXW-1:0]          ax_s1;
	logic signed [AXW-1:0]          ax_next;

	logic signed [INT_WIDTH-1:0] lp_q, hp_q;
	logic signed [PW-1:0]        lp_acc, hp_acc;
	logic signed [WIDE_WIDTH-1:0] lp_wide, hp_round, hp_sum;
	logic signed [INT_WIDTH-1:0] lp_new, hp_new;
	logic [INT_WIDTH-1:0]        mag_new;

	// coefficient registers truncated or zero-extended to the coefficient width
	assign alpha_ext = {{COEF_WIDTH{1'b0}}, cfg.lp_weight};
	assign decay_ext = {{COEF_WIDTH{1'b0}}, cfg.hpf_decay};
	assign alpha     = alpha_ext[COEF_WIDTH-1:0];
	assign decay     = decay_ext[COEF_WIDTH-1:0];
	assign beta      = {1'b1, {COEF_WIDTH{1'b0}}} - {1'b0, alpha};

	// new-sample term of the low-pass, formed on the way in
	assign ax_next = AXW'($signed({1'b0, alpha})) * AXW'(z_sample);

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			x_s1  <= z_sample;
			ax_s1 <= ax_next;
		end
	end

	always_comb begin
		lp_acc   = PW'(ax_s1) + PW'($signed({1'b0, beta})) * PW'(lp_q) + HALF;
		lp_wide  = WIDE_WIDTH'(lp_acc >>> COEF_WIDTH);
		lp_new   = sat_int(lp_wide);
		hp_acc   = PW'($signed({1'b0, decay})) * PW'(hp_q) + HALF;
		hp_round = WIDE_WIDTH'(hp_acc >>> COEF_WIDTH);
		hp_sum   = WIDE_WIDTH'(x_s1) - WIDE_WIDTH'(lp_new) + hp_round;
		hp_new   = sat_int(hp_sum);
		mag_new  = hp_new[INT_WIDTH-1] ? INT_WIDTH'(-hp_new) : INT_WIDTH'(hp_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			hp_q <= '0;
		end else if (ctl.step_s2) begin
			lp_q <= lp_new;
			hp_q <= hp_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step_s2) begin
			filt_s2.lp  <= lp_new;
			filt_s2.hp  <= hp_new;
			filt_s2.mag <= mag_new;
		end
	end

endmodule

// File: rtl/core/bed_detect.sv
// fast and slow hit detection, lockout and result register
module bed_detect #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bed_pkg::pipe_ctl_t             ctl,
	input  bed_pkg::cfg_t                  cfg,
	input  bed_pkg::filt_t                 filt_s2,
	output bed_pkg::flags_t                flags_s3,
	output logic signed [SAMPLE_WIDTH-1:0] hp_out_s3
);
	import bed_pkg::*;

	logic [INT_WIDTH-1:0]        prev_mag_q;
	logic signed [INT_WIDTH-1:0] prev_lp_q;
	logic [CNT_WIDTH-1:0]        run_q, lock_cnt_q;
	logic                        lock_q;

	logic signed [INT_WIDTH:0] dmag, dlp;
	logic [INT_WIDTH:0]        dmag_abs, dlp_abs;
	logic                      fast, slow, drift, bite;
	logic [CNT_WIDTH-1:0]      run_inc, run_next, lock_inc, lock_cnt_next;
	logic                      lock_next;
	logic signed [SAMPLE_WIDTH-1:0] hp_sat;

	always_comb begin
		dmag     = $signed({1'b0, filt_s2.mag}) - $signed({1'b0, prev_mag_q});
		dmag_abs = dmag[INT_WIDTH] ? (INT_WIDTH+1)'(-dmag) : (INT_WIDTH+1)'(dmag);
		fast     = dmag_abs > (INT_WIDTH+1)'(cfg.fast_threshold);

		dlp     = (INT_WIDTH+1)'(filt_s2.lp) - (INT_WIDTH+1)'(prev_lp_q);
		dlp_abs = dlp[INT_WIDTH] ? (INT_WIDTH+1)'(-dlp) : (INT_WIDTH+1)'(dlp);
		drift   = dlp_abs > (INT_WIDTH+1)'(cfg.slow_threshold);

		run_inc  = run_q + 1'b1;
		slow     = drift && (run_inc >= cfg.slow_run_length);
		run_next = (drift && !slow) ? run_inc : '0;

		// lockout count runs first, then a fresh hit may restart it
		lock_inc      = lock_cnt_q + 1'b1;
		lock_next     = lock_q;
		lock_cnt_next = lock_cnt_q;
		if (lock_q) begin
			lock_cnt_next = lock_inc;
			if (lock_inc >= cfg.lockout_length) begin
				lock_next     = 1'b0;
				lock_cnt_next = '0;
			end
		end
		bite = !lock_next && (fast || slow);
		if (bite) begin
			lock_next     = 1'b1;
			lock_cnt_next = '0;
		end

		if (filt_s2.hp[INT_WIDTH-1:SAMPLE_WIDTH-1] ==
				{(INT_WIDTH-SAMPLE_WIDTH+1){filt_s2.hp[INT_WIDTH-1]}}) begin
			hp_sat = filt_s2.hp[SAMPLE_WIDTH-1:0];
		end else if (filt_s2.hp[INT_WIDTH-1]) begin
			hp_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			hp_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mag_q <= '0;
			prev_lp_q  <= '0;
			run_q      <= '0;
			lock_q     <= 1'b0;
			lock_cnt_q <= '0;
		end else if (ctl.step_s3) begin
			prev_mag_q <= filt_s2.mag;
			prev_lp_q  <= filt_s2.lp;
			run_q      <= run_next;
			lock_q     <= lock_next;
			lock_cnt_q <= lock_cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step_s3) begin
			flags_s3.bite       <= bite;
			flags_s3.fast_hit   <= fast;
			flags_s3.slow_hit   <= slow;
			flags_s3.locked_out <= lock_next;
			hp_out_s3           <= hp_sat;
		end
	end

endmodule

// File: rtl/core/accel_bite_event_detector.sv
// top level of the bite event detector: config registers, pipeline flow control
// throughput: one request per cycle while any stage is free or result.ready
// stages: input register with sample product, filter stage, detect and result register
// reset: asynchronous, clears filter and detector state and stage valids, not
// the stage data registers, and returns every config register to its default
module accel_bite_event_detector #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [bed_pkg::IDX_WIDTH-1:0]        wr_index,
	input  logic [bed_pkg::CFG_DATA_WIDTH-1:0]   wr_data,
	bed_sample_if.sink                           sample,
	bed_result_if.source                         result
);
	import bed_pkg::*;

	cfg_t      cfg_q;
	pipe_ctl_t ctl;
	filt_t     filt_s2;
	flags_t    flags_s3;
	logic signed [SAMPLE_WIDTH-1:0] hp_out_s3;
	logic      valid_s1, valid_s2, valid_s3;
	logic      en_s1, en_s2, en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				IDX_LP_WEIGHT:       cfg_q.lp_weight       <= wr_data[COEF_REG_WIDTH-1:0];
				IDX_HPF_DECAY:       cfg_q.hpf_decay       <= wr_data[COEF_REG_WIDTH-1:0];
				IDX_FAST_THRESHOLD:  cfg_q.fast_threshold  <= wr_data[THR_WIDTH-1:0];
				IDX_SLOW_THRESHOLD:  cfg_q.slow_threshold  <= wr_data[THR_WIDTH-1:0];
				IDX_SLOW_RUN_LENGTH: cfg_q.slow_run_length <= wr_data[CNT_WIDTH-1:0];
				IDX_LOCKOUT_LENGTH:  cfg_q.lockout_length  <= wr_data[CNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// a stage moves on when it is empty or the stage after it moves
	assign en_s3 = !valid_s3 || result.ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign ctl.load_s1 = en_s1 && sample.valid;
	assign ctl.step_s2 = en_s2 && valid_s1;
	assign ctl.step_s3 = en_s3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= sample.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	bed_filter #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg      (cfg_q),
		.z_sample (sample.z_sample),
		.filt_s2  (filt_s2)
	);

	bed_detect #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_detect (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg       (cfg_q),
		.filt_s2   (filt_s2),
		.flags_s3  (flags_s3),
		.hp_out_s3 (hp_out_s3)
	);

	assign sample.ready         = en_s1;
	assign result.valid         = valid_s3;
	assign result.bite          = flags_s3.bite;
	assign result.fast_hit      = flags_s3.fast_hit;
	assign result.slow_hit      = flags_s3.slow_hit;
	assign result.locked_out    = flags_s3.locked_out;
	assign result.high_pass_out = hp_out_s3;

	a_bite_locks: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bite |-> result.locked_out)
		else $error("bite without lockout");

	a_bite_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bite |-> result.fast_hit || result.slow_hit)
		else $error("bite without a hit");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> valid_s1 && valid_s2 && valid_s3)
		else $error("request refused with a free stage");

endmodule

// File: test/bed_checker.sv
// checker of the bite event detector: watches both channels and the register port
`timescale 1ns / 100ps

module bed_checker #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [bed_pkg::IDX_WIDTH-1:0]      wr_index,
	input  logic [bed_pkg::CFG_DATA_WIDTH-1:0] wr_data,
	bed_sample_if                              sample,
	bed_result_if                              result,
	output int                                 fault_count,
	output int                                 detections_due
);
	import bed_pkg::*;

	localparam longint COEF_ONE  = longint'(1) << COEF_WIDTH;
	localparam longint COEF_HALF = longint'(1) << (COEF_WIDTH - 1);

	typedef struct packed {
		logic                           bite;
		logic                           fast_hit;
		logic                           slow_hit;
		logic                           locked_out;
		logic signed [SAMPLE_WIDTH-1:0] high_pass_out;
	} detection_t;

	cfg_t                        cfg;
	logic signed [INT_WIDTH-1:0] lp_state;
	logic signed [INT_WIDTH-1:0] hp_state;
	logic signed [INT_WIDTH-1:0] lp_last;
	logic [INT_WIDTH-1:0]        mag_last;
	logic [CNT_WIDTH-1:0]        drift_run;
	logic [CNT_WIDTH-1:0]        lock_count;
	logic                        lock_on;

	detection_t expected_detections[$];
	detection_t want;
	detection_t got;

	function automatic longint clamp_signed(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic longint abs64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// one sample through the filters and both detectors, state updated in place
	function automatic detection_t detect_step(input logic signed [SAMPLE_WIDTH-1:0] z);
		longint     x;
		longint     alpha;
		longint     decay;
		longint     lp_old;
		longint     hp_old;
		longint     lp;
		longint     hp;
		longint     mag;
		longint     hp_narrow;
		longint     fast_thr;
		longint     slow_thr;
		logic       fast;
		logic       slow;
		detection_t d;
		x        = z;
		alpha    = longint'(cfg.lp_weight) & (COEF_ONE - 1);
		decay    = longint'(cfg.hpf_decay) & (COEF_ONE - 1);
		lp_old   = lp_state;
		hp_old   = hp_state;
		fast_thr = cfg.fast_threshold;
		slow_thr = cfg.slow_threshold;
		lp = (alpha * x + (COEF_ONE - alpha) * lp_old + COEF_HALF) >>> COEF_WIDTH;
		lp = clamp_signed(lp, INT_WIDTH);
		hp = clamp_signed(x - lp + ((decay * hp_old + COEF_HALF) >>> COEF_WIDTH), INT_WIDTH);
		mag = abs64(hp);
		fast = abs64(longint'(mag_last) - mag) > fast_thr;
		slow = 1'b0;
		d.bite = 1'b0;
		if (abs64(longint'(lp_last) - lp) > slow_thr) begin
			drift_run = drift_run + 1'b1;
			if (drift_run >= cfg.slow_run_length) begin
				slow      = 1'b1;
				drift_run = '0;
			end
		end else begin
			drift_run = '0;
		end
		if (lock_on) begin
			lock_count = lock_count + 1'b1;
			if (lock_count >= cfg.lockout_length) begin
				lock_on    = 1'b0;
				lock_count = '0;
			end
		end
		if (!lock_on && (fast || slow)) begin
			d.bite     = 1'b1;
			lock_on    = 1'b1;
			lock_count = '0;
		end
		lp_state  = lp[INT_WIDTH-1:0];
		hp_state  = hp[INT_WIDTH-1:0];
		lp_last   = lp[INT_WIDTH-1:0];
		mag_last  = mag[INT_WIDTH-1:0];
		hp_narrow = clamp_signed(hp, SAMPLE_WIDTH);
		d.fast_hit      = fast;
		d.slow_hit      = slow;
		d.locked_out    = lock_on;
		d.high_pass_out = hp_narrow[SAMPLE_WIDTH-1:0];
		return d;
	endfunction

	task automatic check_field(input string name, input logic signed [SAMPLE_WIDTH:0] exp_v,
			input logic signed [SAMPLE_WIDTH:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg        = CFG_RESET;
			lp_state   = '0;
			hp_state   = '0;
			lp_last    = '0;
			mag_last   = '0;
			drift_run  = '0;
			lock_count = '0;
			lock_on    = 1'b0;
			expected_detections.delete();
			fault_count    = 0;
			detections_due = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					IDX_LP_WEIGHT:       cfg.lp_weight       = wr_data[COEF_REG_WIDTH-1:0];
					IDX_HPF_DECAY:       cfg.hpf_decay       = wr_data[COEF_REG_WIDTH-1:0];
					IDX_FAST_THRESHOLD:  cfg.fast_threshold  = wr_data[THR_WIDTH-1:0];
					IDX_SLOW_THRESHOLD:  cfg.slow_threshold  = wr_data[THR_WIDTH-1:0];
					IDX_SLOW_RUN_LENGTH: cfg.slow_run_length = wr_data[CNT_WIDTH-1:0];
					IDX_LOCKOUT_LENGTH:  cfg.lockout_length  = wr_data[CNT_WIDTH-1:0];
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				got.bite          = result.bite;
				got.fast_hit      = result.fast_hit;
				got.slow_hit      = result.slow_hit;
				got.locked_out    = result.locked_out;
				got.high_pass_out = result.high_pass_out;
				if (expected_detections.size() == 0) begin
					$error("result with no request outstanding");
					fault_count++;
				end else begin
					want = expected_detections.pop_front();
					check_field("bite", want.bite, got.bite);
					check_field("fast_hit", want.fast_hit, got.fast_hit);
					check_field("slow_hit", want.slow_hit, got.slow_hit);
					check_field("locked_out", want.locked_out, got.locked_out);
					check_field("high_pass_out", want.high_pass_out, got.high_pass_out);
				end
			end
			if (sample.valid && sample.ready) begin
				expected_detections.push_back(detect_step(sample.z_sample));
			end
			detections_due = expected_detections.size();
		end
	end

endmodule

// File: test/tb.sv
// testbench top of the bite event detector: clock, reset, register writes, sample stimulus, verdict
`timescale 1ns / 100ps

module tb;
	import bed_pkg::*;

	localparam int     PERIOD       = 20;
	localparam int     SAMPLE_WIDTH = 16;
	localparam int     COEF_WIDTH   = 16;
	localparam longint CYCLE_LIMIT  = 400000;

	localparam logic [IDX_WIDTH-1:0] IDX_UNUSED_LO = 3'd6;
	localparam logic [IDX_WIDTH-1:0] IDX_UNUSED_HI = 3'd7;

	typedef enum {SEG_QUIET, SEG_SPIKE, SEG_RAMP, SEG_NOISE, SEG_EXTREME} seg_kind_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      wr_en;
	logic [IDX_WIDTH-1:0]      wr_index;
	logic [CFG_DATA_WIDTH-1:0] wr_data;
	int                        fault_count;
	int                        detections_due;
	longint                    cycle_count;
	bit                        idle_on;

	seg_kind_t seg_kind;
	int        seg_left;
	int        base;
	int        step;
	int        amp;

	bed_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) sample_ch ();
	bed_result_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) result_ch ();

	accel_bite_event_detector #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.sample  (sample_ch),
		.result  (result_ch)
	);

	bed_checker #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_WIDTH  (COEF_WIDTH)
	) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.sample        (sample_ch),
		.result        (result_ch),
		.fault_count   (fault_count),
		.detections_due(detections_due)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic int clamp16(input int v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] alpha, input logic [15:0] decay,
			input logic [15:0] fast_d, input logic [15:0] slow_d,
			input logic [15:0] run_d, input logic [15:0] lock_d);
		write_reg(IDX_LP_WEIGHT, alpha);
		write_reg(IDX_HPF_DECAY, decay);
		write_reg(IDX_FAST_THRESHOLD, fast_d);
		write_reg(IDX_SLOW_THRESHOLD, slow_d);
		write_reg(IDX_SLOW_RUN_LENGTH, run_d);
		write_reg(IDX_LOCKOUT_LENGTH, lock_d);
	endtask

	task automatic random_config();
		logic [15:0] alpha;
		logic [15:0] decay;
		logic [15:0] fast_d;
		logic [15:0] slow_d;
		logic [15:0] run_d;
		logic [15:0] lock_d;
		logic [31:0] r;
		r      = $urandom;
		alpha  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 40000));
		decay  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(40000, 65535));
		fast_d = 16'($urandom_range(0, 1500));
		fast_d[15] = r[0];
		slow_d = 16'($urandom_range(0, 300));
		slow_d[15] = r[1];
		run_d  = r[31:16];
		run_d[3:0]  = 4'($urandom_range(0, 15));
		lock_d = r[17:2];
		lock_d[3:0] = 4'($urandom_range(0, 15));
		set_config(alpha, decay, fast_d, slow_d, run_d, lock_d);
	endtask

	task automatic send(input logic signed [SAMPLE_WIDTH-1:0] x);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			sample_ch.valid    <= 1'b0;
			sample_ch.z_sample <= SAMPLE_WIDTH'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.valid    <= 1'b1;
		sample_ch.z_sample <= x;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (detections_due != 0) @(negedge clk);
	endtask

	// mostly plausible motion: quiet baseline, bite spikes, slow drifts; some noise and rail values
	task automatic gen_sample(output logic signed [SAMPLE_WIDTH-1:0] x);
		int pick;
		int v;
		if (seg_left == 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				seg_kind = SEG_QUIET;
				seg_left = $urandom_range(4, 30);
				base     = 4096 + int'($urandom_range(0, 4000)) - 2000;
			end else if (pick < 65) begin
				seg_kind = SEG_SPIKE;
				seg_left = $urandom_range(1, 3);
				amp      = $urandom_range(1500, 20000);
				if ($urandom_range(0, 1) == 1) begin
					amp = -amp;
				end
			end else if (pick < 82) begin
				seg_kind = SEG_RAMP;
				seg_left = $urandom_range(3, 20);
				step     = $urandom_range(40, 900);
				if ($urandom_range(0, 1) == 1) begin
					step = -step;
				end
			end else if (pick < 94) begin
				seg_kind = SEG_NOISE;
				seg_left = $urandom_range(1, 10);
			end else begin
				seg_kind = SEG_EXTREME;
				seg_left = $urandom_range(1, 6);
			end
		end
		seg_left--;
		case (seg_kind)
			SEG_QUIET:   v = base + int'($urandom_range(0, 80)) - 40;
			SEG_SPIKE:   v = base + amp;
			SEG_RAMP: begin
				base = clamp16(base + step);
				v    = base;
			end
			SEG_NOISE:   v = $urandom;
			default:     v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
		endcase
		if (seg_kind != SEG_NOISE) begin
			v = clamp16(v);
		end
		x = v[SAMPLE_WIDTH-1:0];
	endtask

	task automatic random_items(input int n);
		logic signed [SAMPLE_WIDTH-1:0] x;
		repeat (n) begin
			gen_sample(x);
			send(x);
		end
	endtask

	// park the low-pass at one rail, freeze it, then push the high-pass into clamping
	task automatic saturate(input bit positive);
		logic signed [SAMPLE_WIDTH-1:0] top;
		logic signed [SAMPLE_WIDTH-1:0] bottom;
		logic signed [SAMPLE_WIDTH-1:0] jit;
		logic signed [SAMPLE_WIDTH-1:0] x;
		top    = positive ? 16'sh7FFF : 16'sh8000;
		bottom = positive ? 16'sh8000 : 16'sh7FFF;
		write_reg(IDX_LP_WEIGHT, 16'hFFFF);
		repeat (4) send(bottom);
		drain();
		write_reg(IDX_LP_WEIGHT, 16'h0000);
		write_reg(IDX_HPF_DECAY, 16'hFFFF);
		repeat (160) begin
			jit = SAMPLE_WIDTH'($urandom_range(0, 15));
			x   = positive ? top - jit : top + jit;
			send(x);
		end
		drain();
	endtask

	always begin : result_stall
		int hold;
		@(negedge clk);
		if (idle_on && arst_n && $urandom_range(0, 5) == 0) begin
			hold = $urandom_range(1, 9);
			result_ch.ready <= 1'b0;
			repeat (hold) @(negedge clk);
		end
		result_ch.ready <= 1'b1;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic signed [SAMPLE_WIDTH-1:0] directed_z[$] = '{
			16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 16'sh1000,
			16'sh1000, 16'sh1000, 16'sh3000, 16'sh1000, 16'sh1000, -16'sh1000,
			16'sh1000, 16'sh0000
		};
		logic signed [SAMPLE_WIDTH-1:0] zero_len_z[$] = '{
			16'sh1000, 16'sh3000, 16'sh1000, -16'sh2000, 16'sh0000
		};
		arst_n             <= 1'b0;
		wr_en              <= 1'b0;
		wr_index           <= IDX_LP_WEIGHT;
		wr_data            <= '0;
		sample_ch.valid    <= 1'b0;
		sample_ch.z_sample <= '0;
		result_ch.ready    <= 1'b0;
		idle_on  = 1'b1;
		seg_kind = SEG_QUIET;
		seg_left = 0;
		base     = 4096;
		step     = 0;
		amp      = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// reset defaults
		foreach (directed_z[i]) begin
			send(directed_z[i]);
		end
		random_items(200);
		drain();

		// lowest thresholds and decay, full low-pass weight, zero run and lockout lengths, unused indexes
		set_config(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		write_reg(IDX_UNUSED_LO, CFG_DATA_WIDTH'($urandom));
		write_reg(IDX_UNUSED_HI, 16'hFFFF);
		foreach (zero_len_z[i]) begin
			send(zero_len_z[i]);
		end
		random_items(150);
		drain();

		// highest settings but zero low-pass weight, masked bits set
		set_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_items(100);
		drain();

		saturate(1'b1);
		saturate(1'b0);

		repeat (4) begin
			random_config();
			random_items(190);
			drain();
		end

		idle_on = 1'b0;
		random_config();
		random_items(190);
		drain();

		repeat (10) @(negedge clk);
		if (fault_count == 0 && detections_due == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
